>>> design/sgnd_pkg.sv
// ----------------------------------------------------------------------------
// sgnd_pkg
// Shared types and constants of the stepper gauge needle driver: field
// widths, request codes, register indexes and the mapping request bundle.
// ----------------------------------------------------------------------------
package sgnd_pkg;

	// field widths
	localparam int ANGLE_W    = 10;
	localparam int VALUE_W    = 16;
	localparam int IVL_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// serial multiply and divide widths
	localparam int MAG_A_W = 17;                 // |x - in_lo|
	localparam int MAG_B_W = 11;                 // |out_hi - out_lo|
	localparam int DEN_W   = 17;                 // |in_hi - in_lo|
	localparam int PROD_W  = MAG_A_W + MAG_B_W;  // product and quotient
	localparam int CNT_W   = $clog2(PROD_W);

	localparam logic signed [VALUE_W-1:0] ANGLE_MAX   = 16'sd359;
	localparam logic signed [DEN_W-1:0]   PERCENT_MAX = 17'sd100;

	// request codes
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_ANGLE   = 2'd1,
		REQ_PERCENT = 2'd2,
		REQ_VALUE   = 2'd3
	} req_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IVL   = 3'd4;

	// register reset values
	localparam logic signed [ANGLE_W-1:0] ANGLE_LOW_RST  = 10'sd0;
	localparam logic signed [ANGLE_W-1:0] ANGLE_HIGH_RST = 10'sd359;
	localparam logic signed [VALUE_W-1:0] VALUE_LOW_RST  = 16'sd0;
	localparam logic signed [VALUE_W-1:0] VALUE_HIGH_RST = 16'sd0;
	localparam logic [IVL_W-1:0]          STEP_IVL_RST   = 8'd2;
	localparam logic [IVL_W-1:0]          MS_SAT         = 8'd255;

	// one mapping job: magnitudes and the sign of the quotient
	typedef struct packed {
		logic [MAG_A_W-1:0] a_mag;
		logic [MAG_B_W-1:0] b_mag;
		logic [DEN_W-1:0]   den_mag;
		logic               neg;
	} map_req_t;

endpackage

>>> design/stepper_gauge_needle_driver_top.sv
// ----------------------------------------------------------------------------
// stepper_gauge_needle_driver_top
// Stepper gauge needle driver: keeps needle and target angle, maps percent
// and display value targets onto the angle range, steps on millisecond ticks.
// ----------------------------------------------------------------------------
// Tick, set-angle and zero-span value beats pass the done state into the output register.
// Percent and value beats first run a shift-add multiply and a restoring divide, then a
// state that takes the quotient, and then the load of the output register.
// One beat is worked at a time; the next is accepted once the result sits in the output
// register, and output stalls hold that back.
// Reset clears the sequencer, needle and valid state and loads register defaults; the result fields are not reset.
module stepper_gauge_needle_driver_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [sgnd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sgnd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           req_type,
	input  logic signed [sgnd_pkg::VALUE_W-1:0]  operand,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 step_pulse,
	output logic                                 step_down,
	output logic signed [sgnd_pkg::VALUE_W-1:0]  needle_angle,
	output logic                                 adjusting,
	output logic                                 span_error
);
	import sgnd_pkg::*;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_MAP  = 3'b010,
		T_DONE = 3'b100
	} tstate_t;

	tstate_t                    state_q;

	logic signed [ANGLE_W-1:0]  angle_low_q;
	logic signed [ANGLE_W-1:0]  angle_high_q;
	logic signed [VALUE_W-1:0]  value_low_q;
	logic signed [VALUE_W-1:0]  value_high_q;
	logic [IVL_W-1:0]           step_ivl_q;

	logic signed [VALUE_W-1:0]  needle_q;
	logic signed [VALUE_W-1:0]  target_q;
	logic [IVL_W-1:0]           ms_q;

	logic                       pend_pulse_q;
	logic                       pend_down_q;
	logic                       pend_err_q;
	logic                       out_valid_q;

	logic                       accept;
	req_t                       req;
	logic [IVL_W-1:0]           ms_next;
	logic                       do_step;
	logic signed [VALUE_W-1:0]  angle_clamped;
	logic signed [MAG_A_W-1:0]  x_diff;
	logic signed [DEN_W-1:0]    den_s;
	logic signed [MAG_B_W-1:0]  span_a;
	logic                       zero_span;
	map_req_t                   map_req;
	logic                       map_start;
	logic                       map_done;
	logic signed [VALUE_W-1:0]  map_quot;
	logic signed [VALUE_W-1:0]  map_sum;
	logic signed [VALUE_W-1:0]  map_target;
	logic                       out_load;

	assign in_ready = (state_q == T_IDLE);
	assign accept   = in_valid && in_ready;
	assign req      = req_t'(req_type);

	// tick: saturating ms count and step decision
	always_comb begin
		ms_next = (ms_q < MS_SAT) ? ms_q + 1'b1 : MS_SAT;
		do_step = (needle_q != target_q) && (ms_next > step_ivl_q);
	end

	// direct angle target, clamped above
	assign angle_clamped = (operand > ANGLE_MAX) ? ANGLE_MAX : operand;

	// mapping operands: x - in_lo, out span, in span
	always_comb begin
		span_a = {angle_high_q[ANGLE_W-1], angle_high_q}
		       - {angle_low_q[ANGLE_W-1], angle_low_q};
		if (req == REQ_PERCENT) begin
			x_diff = $signed({9'b0, operand[7:0]});
			den_s  = PERCENT_MAX;
		end else begin
			x_diff = {operand[VALUE_W-1], operand} - {value_low_q[VALUE_W-1], value_low_q};
			den_s  = {value_high_q[VALUE_W-1], value_high_q}
			       - {value_low_q[VALUE_W-1], value_low_q};
		end
		zero_span       = (value_high_q == value_low_q);
		map_req.a_mag   = x_diff[MAG_A_W-1] ? MAG_A_W'(-x_diff) : MAG_A_W'(x_diff);
		map_req.b_mag   = span_a[MAG_B_W-1] ? MAG_B_W'(-span_a) : MAG_B_W'(span_a);
		map_req.den_mag = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
		map_req.neg     = x_diff[MAG_A_W-1] ^ span_a[MAG_B_W-1] ^ den_s[DEN_W-1];
	end

	assign map_start = accept && ((req == REQ_PERCENT) || (req == REQ_VALUE && !zero_span));

	sgnd_mapdiv u_mapdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (map_start),
		.req    (map_req),
		.done   (map_done),
		.quot   (map_quot)
	);

	// add out_lo, wrap to 16 bits, clamp above
	always_comb begin
		map_sum    = map_quot + VALUE_W'(angle_low_q);
		map_target = (map_sum > ANGLE_MAX) ? ANGLE_MAX : map_sum;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_low_q  <= ANGLE_LOW_RST;
			angle_high_q <= ANGLE_HIGH_RST;
			value_low_q  <= VALUE_LOW_RST;
			value_high_q <= VALUE_HIGH_RST;
			step_ivl_q   <= STEP_IVL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ANGLE_LOW:  angle_low_q  <= cfg_wdata[ANGLE_W-1:0];
				REG_ANGLE_HIGH: angle_high_q <= cfg_wdata[ANGLE_W-1:0];
				REG_VALUE_LOW:  value_low_q  <= cfg_wdata[VALUE_W-1:0];
				REG_VALUE_HIGH: value_high_q <= cfg_wdata[VALUE_W-1:0];
				REG_STEP_IVL:   step_ivl_q   <= cfg_wdata[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_load = (state_q == T_DONE) && (!out_valid_q || out_ready);

	// sequencer and needle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			needle_q     <= '0;
			target_q     <= '0;
			ms_q         <= '0;
			pend_pulse_q <= 1'b0;
			pend_down_q  <= 1'b0;
			pend_err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						pend_pulse_q <= 1'b0;
						pend_down_q  <= 1'b0;
						pend_err_q   <= 1'b0;
						state_q      <= T_DONE;
						unique case (req)
							REQ_TICK: begin
								ms_q <= ms_next;
								if (do_step) begin
									pend_pulse_q <= 1'b1;
									ms_q         <= '0;
									if (needle_q < target_q) begin
										needle_q <= needle_q + 16'sd1;
									end else begin
										needle_q    <= needle_q - 16'sd1;
										pend_down_q <= 1'b1;
									end
								end
							end
							REQ_ANGLE:   target_q <= angle_clamped;
							REQ_PERCENT: state_q  <= T_MAP;
							REQ_VALUE: begin
								if (zero_span) pend_err_q <= 1'b1;
								else state_q <= T_MAP;
							end
							default: begin
							end
						endcase
					end
				end
				T_MAP: begin
					if (map_done) begin
						target_q <= map_target;
						state_q  <= T_DONE;
					end
				end
				T_DONE: begin
					if (out_load) state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			step_pulse   <= pend_pulse_q;
			step_down    <= pend_down_q;
			needle_angle <= needle_q;
			adjusting    <= (needle_q != target_q);
			span_error   <= pend_err_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_target_max: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= ANGLE_MAX)
		else $error("target above maximum angle");
	a_needle_max: assert property (@(posedge clk) disable iff (!arst_n)
		needle_q <= ANGLE_MAX)
		else $error("needle above maximum angle");
	a_step_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && step_pulse |-> !span_error)
		else $error("step and span error on one beat");
	a_down_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !step_pulse |-> !step_down)
		else $error("direction set without a step");
`endif

endmodule

>>> design/sgnd_mapdiv.sv
// ----------------------------------------------------------------------------
// sgnd_mapdiv
// Bit-serial scaling unit: shift-add multiply, one multiplier bit per cycle,
// then restoring divide, one quotient bit per cycle. Returns the low 16 bits
// of the signed quotient, truncated toward zero.
// ----------------------------------------------------------------------------
module sgnd_mapdiv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  sgnd_pkg::map_req_t        req,
	output logic                      done,
	output logic signed [15:0]        quot
);
	import sgnd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} mstate_t;

	mstate_t              state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [MAG_B_W-1:0]   mplier_q;
	logic [PROD_W-1:0]    acc_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic                 neg_q;

	logic [DEN_W:0]       rem_sh;
	logic [DEN_W:0]       rem_sub;
	logic                 q_bit;

	// one restoring divide step
	always_comb begin
		rem_sh  = {rem_q, acc_q[PROD_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		q_bit   = (rem_sh >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MAG_B_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mcand_q  <= PROD_W'(req.a_mag);
					mplier_q <= req.b_mag;
					acc_q    <= '0;
					den_q    <= req.den_mag;
					neg_q    <= req.neg;
				end
			end
			S_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MAG_B_W-1:1]};
				rem_q    <= '0;
			end
			S_DIV: begin
				rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				acc_q <= {acc_q[PROD_W-2:0], q_bit};
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == S_FIN);
	assign quot = neg_q ? -$signed(acc_q[15:0]) : $signed(acc_q[15:0]);

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("mapdiv started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_IDLE)
		else $error("mapdiv did not return to idle");
	a_cnt_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q < CNT_W'(MAG_B_W))
		else $error("mapdiv multiply count overrun");
`endif

endmodule

>>> bench/stepper_gauge_needle_driver_top_tb.sv
// ----------------------------------------------------------------------------
// stepper_gauge_needle_driver_top_tb
// Self-checking bench for the needle driver. Drives tick and set-target
// beats through the valid/ready input channel, keeps its own model of the
// needle, target and step timer, and checks every result beat field by field.
// Register sets are loaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module stepper_gauge_needle_driver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgnd_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 60;
	localparam int BLOCK_BEATS  = 48;
	localparam int SLOW_BEATS   = 300;

	// one expected result beat
	typedef struct packed {
		logic                      pulse;
		logic                      down;
		logic signed [VALUE_W-1:0] angle;
		logic                      adj;
		logic                      err;
	} gauge_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 req_type = REQ_TICK;
	logic signed [VALUE_W-1:0]  operand = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       step_pulse;
	logic                       step_down;
	logic signed [VALUE_W-1:0]  needle_angle;
	logic                       adjusting;
	logic                       span_error;

	// model copy of the registers
	logic signed [ANGLE_W-1:0]  ang_lo = ANGLE_LOW_RST;
	logic signed [ANGLE_W-1:0]  ang_hi = ANGLE_HIGH_RST;
	logic signed [VALUE_W-1:0]  val_lo = VALUE_LOW_RST;
	logic signed [VALUE_W-1:0]  val_hi = VALUE_HIGH_RST;
	logic [IVL_W-1:0]           ivl_ms = STEP_IVL_RST;

	// model copy of the needle state
	logic signed [VALUE_W-1:0]  needle = '0;
	logic signed [VALUE_W-1:0]  target = '0;
	logic [IVL_W-1:0]           ms_count = '0;

	gauge_result_t              expected_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int beats_sent     = 0;
	int results_seen   = 0;
	int steps_seen     = 0;
	int span_errs_seen = 0;
	int config_loads   = 0;
	int cycle_count    = 0;

	stepper_gauge_needle_driver_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.operand      (operand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.step_pulse   (step_pulse),
		.step_down    (step_down),
		.needle_angle (needle_angle),
		.adjusting    (adjusting),
		.span_error   (span_error)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("run did not complete within %0d cycles", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// linear map onto the angle range, truncating toward zero, wrap then clamp
	function automatic logic signed [VALUE_W-1:0] map_to_angle(input longint x,
			input longint in_lo, input longint in_hi);
		longint scaled;
		logic signed [VALUE_W-1:0] wrapped;
		scaled = (x - in_lo) * (longint'(ang_hi) - longint'(ang_lo)) / (in_hi - in_lo)
			+ longint'(ang_lo);
		wrapped = scaled[VALUE_W-1:0];
		return (wrapped > ANGLE_MAX) ? ANGLE_MAX : wrapped;
	endfunction

	// advance the needle model by one request and return its result beat
	function automatic gauge_result_t predict_needle(input req_t kind,
			input logic signed [VALUE_W-1:0] arg);
		gauge_result_t r;
		r = '0;
		case (kind)
			REQ_TICK: begin
				if (ms_count != MS_SAT)
					ms_count++;
				if (needle != target && ms_count > ivl_ms) begin
					if (needle < target) begin
						needle++;
					end else begin
						needle--;
						r.down = 1'b1;
					end
					r.pulse  = 1'b1;
					ms_count = '0;
				end
			end
			REQ_ANGLE: target = (arg > ANGLE_MAX) ? ANGLE_MAX : arg;
			REQ_PERCENT: target = map_to_angle(longint'(arg[7:0]), 0, longint'(PERCENT_MAX));
			default: begin
				if (val_hi == val_lo)
					r.err = 1'b1;
				else
					target = map_to_angle(longint'(arg), longint'(val_lo), longint'(val_hi));
			end
		endcase
		r.angle = needle;
		r.adj   = (needle != target);
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		gauge_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (step_pulse === 1'b1)
				steps_seen++;
			if (span_error === 1'b1)
				span_errs_seen++;
			if (expected_results.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("step_pulse", 32'(want.pulse), 32'(step_pulse));
				check_field("step_down", 32'(want.down), 32'(step_down));
				check_field("needle_angle", 32'(want.angle), 32'(needle_angle));
				check_field("adjusting", 32'(want.adj), 32'(adjusting));
				check_field("span_error", 32'(want.err), 32'(span_error));
			end
		end
	end

	// send one request beat, with a random idle gap in front of it
	task automatic send_request(input req_t kind, input logic signed [VALUE_W-1:0] arg);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		operand  <= arg;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(predict_needle(kind, arg));
		beats_sent++;
	endtask

	// drop valid and let every outstanding result come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// write all five registers back to back, block must be idle
	task automatic load_config(input logic signed [ANGLE_W-1:0] a_lo,
			input logic signed [ANGLE_W-1:0] a_hi, input logic signed [VALUE_W-1:0] v_lo,
			input logic signed [VALUE_W-1:0] v_hi, input logic [IVL_W-1:0] ivl);
		put_reg(REG_ANGLE_LOW, {{(CFG_DATA_W-ANGLE_W){a_lo[ANGLE_W-1]}}, a_lo});
		put_reg(REG_ANGLE_HIGH, {{(CFG_DATA_W-ANGLE_W){a_hi[ANGLE_W-1]}}, a_hi});
		put_reg(REG_VALUE_LOW, v_lo);
		put_reg(REG_VALUE_HIGH, v_hi);
		put_reg(REG_STEP_IVL, {{(CFG_DATA_W-IVL_W){1'b0}}, ivl});
		cfg_wr_en <= 1'b0;
		ang_lo = a_lo;
		ang_hi = a_hi;
		val_lo = v_lo;
		val_hi = v_hi;
		ivl_ms = ivl;
		config_loads++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// set requests under the reset register values
	task automatic test_set_requests();
		send_request(REQ_VALUE, 16'sd123);       // zero value span
		send_request(REQ_TICK, 16'sd0);          // target already reached
		send_request(REQ_ANGLE, 16'sd400);       // clamped to max angle
		send_request(REQ_ANGLE, 16'sh7FFF);
		send_request(REQ_PERCENT, 16'sh8064);    // upper byte ignored
		send_request(REQ_PERCENT, -16'sd1);      // percent 255, clamped
		send_request(REQ_PERCENT, 16'sd0);
	endtask

	// needle steps up, then down toward the most negative target
	task automatic test_needle_steps();
		send_request(REQ_ANGLE, 16'sd2);
		repeat (4) send_request(REQ_TICK, 16'sd0);
		send_request(REQ_ANGLE, -16'sd32768);
		repeat (2) send_request(REQ_TICK, -16'sd1);
	endtask

	// widest spans and mapped angles that wrap past 16 bits
	task automatic test_mapping_extremes();
		wait_idle();
		load_config(-10'sd359, 10'sd359, -16'sd32768, 16'sd32767, 8'd0);
		send_request(REQ_VALUE, -16'sd32768);
		send_request(REQ_VALUE, 16'sd32767);
		wait_idle();
		load_config(-10'sd359, 10'sd359, 16'sd0, 16'sd1, 8'd0);
		send_request(REQ_VALUE, 16'sd32767);
		send_request(REQ_VALUE, -16'sd32768);
		send_request(REQ_PERCENT, 16'sd255);
		send_request(REQ_PERCENT, 16'sd50);
	endtask

	// longest and shortest step intervals
	task automatic test_interval_extremes();
		wait_idle();
		load_config(10'sd0, 10'sd359, 16'sd0, 16'sd0, 8'd255);
		send_request(REQ_ANGLE, 16'sd5);
		repeat (2) send_request(REQ_TICK, 16'sd0);
		wait_idle();
		load_config(10'sd0, 10'sd359, 16'sd0, 16'sd0, 8'd0);
		repeat (3) send_request(REQ_TICK, 16'sd0);
	endtask

	task automatic randomize_config(input bit slow_steps);
		logic signed [ANGLE_W-1:0] a_lo, a_hi;
		logic signed [VALUE_W-1:0] v_lo, v_hi;
		logic [IVL_W-1:0] ivl;
		a_lo = ANGLE_W'(int'($urandom_range(718)) - 359);
		a_hi = ANGLE_W'(int'($urandom_range(718)) - 359);
		v_lo = VALUE_W'($urandom);
		case ($urandom_range(4))
			0: v_hi = v_lo;
			1: v_hi = VALUE_W'(int'(v_lo) + int'($urandom_range(1, 200)));
			default: v_hi = VALUE_W'($urandom);
		endcase
		if (slow_steps)
			ivl = IVL_W'($urandom_range(253, 255));
		else if ($urandom_range(5) == 0)
			ivl = IVL_W'($urandom_range(255));
		else
			ivl = IVL_W'($urandom_range(4));
		load_config(a_lo, a_hi, v_lo, v_hi, ivl);
	endtask

	// one random request or a run of ticks; returns how many beats went out
	task automatic send_random_request(input int burst_max, output int count);
		int pick, lo, hi;
		logic signed [VALUE_W-1:0] arg;
		pick  = $urandom_range(99);
		arg   = VALUE_W'($urandom);
		count = 1;
		if (pick < 10 && burst_max >= 2) begin
			count = $urandom_range(2, burst_max);
			repeat (count) send_request(REQ_TICK, VALUE_W'($urandom));
		end else if (pick < 55) begin
			send_request(REQ_TICK, arg);
		end else if (pick < 72) begin
			if ($urandom_range(2) != 0)
				arg = VALUE_W'(int'(needle) + int'($urandom_range(20)) - 10);
			send_request(REQ_ANGLE, arg);
		end else if (pick < 85) begin
			if ($urandom_range(3) != 0)
				arg[7:0] = 8'($urandom_range(100));
			send_request(REQ_PERCENT, arg);
		end else begin
			if ($urandom_range(3) != 0) begin
				lo  = (val_lo < val_hi) ? int'(val_lo) : int'(val_hi);
				hi  = (val_lo < val_hi) ? int'(val_hi) : int'(val_lo);
				arg = VALUE_W'(lo + int'($urandom_range(hi - lo)));
			end
			send_request(REQ_VALUE, arg);
		end
	endtask

	// random traffic in four register settings; the last one has slow steps if asked
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input bit with_slow);
		int sent, n, budget, burst;
		bit slow;
		set_idling(send_pct, recv_pct);
		for (int blk = 0; blk < 4; blk++) begin
			wait_idle();
			slow = with_slow && (blk == 3);
			randomize_config(slow);
			budget = slow ? SLOW_BEATS : BLOCK_BEATS;
			sent = 0;
			while (sent < budget) begin
				burst = slow ? 300 : 12;
				if (burst > budget - sent)
					burst = budget - sent;
				send_random_request(burst, n);
				sent += n;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0, 0);
		test_set_requests();
		test_needle_steps();
		test_mapping_extremes();
		test_interval_extremes();
		test_random_traffic(0, 0, 1'b1);
		test_random_traffic(86, 0, 1'b0);
		test_random_traffic(0, 86, 1'b0);
		test_random_traffic(14, 14, 1'b0);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d request beats, %0d results checked, %0d needle steps, %0d span errors",
			beats_sent, results_seen, steps_seen, span_errs_seen);
		$display("%0d register loads across four sender/receiver idle phases",
			config_loads);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
